>>> rtl/drac_pkg.sv
`default_nettype none

package drac_pkg;

  // Default grid size
  localparam int GridWidth  = 64;
  localparam int GridHeight = 64;

  // Fixed field widths
  localparam int CoordW  = 6;
  localparam int NearW   = 4;
  localparam int FarW    = 5;
  localparam int ThrW    = 5;
  localparam int CfgIdxW = 2;

  // Neighborhood scan: 8 Moore neighbors, then the 20-cell ring
  localparam int NumSteps = 28;
  localparam int StepW    = 5;

  localparam logic [ThrW-1:0] NearLowRst  = 5'd1;
  localparam logic [ThrW-1:0] NearHighRst = 5'd4;
  localparam logic [ThrW-1:0] FarLowRst   = 5'd5;
  localparam logic [ThrW-1:0] FarHighRst  = 5'd12;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNearLow  = 2'd0,
    CfgNearHigh = 2'd1,
    CfgFarLow   = 2'd2,
    CfgFarHigh  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [2:0] dc;
    logic signed [2:0] dr;
    logic              far;
  } step_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_in;
    logic reduce;
    logic issue_center;
    logic issue_step;
    logic clear_acc;
    logic mem_write;
    logic load_out;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic reduced;
    logic is_eval;
    logic last_step;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

  function automatic step_t step_offset(input logic [StepW-1:0] idx);
    step_t s;
    s = '{dc: 3'sd0, dr: 3'sd0, far: 1'b0};
    case (idx)
      5'd0:  s = '{dc: -3'sd1, dr: -3'sd1, far: 1'b0};
      5'd1:  s = '{dc:  3'sd0, dr: -3'sd1, far: 1'b0};
      5'd2:  s = '{dc:  3'sd1, dr: -3'sd1, far: 1'b0};
      5'd3:  s = '{dc: -3'sd1, dr:  3'sd1, far: 1'b0};
      5'd4:  s = '{dc:  3'sd0, dr:  3'sd1, far: 1'b0};
      5'd5:  s = '{dc:  3'sd1, dr:  3'sd1, far: 1'b0};
      5'd6:  s = '{dc: -3'sd1, dr:  3'sd0, far: 1'b0};
      5'd7:  s = '{dc:  3'sd1, dr:  3'sd0, far: 1'b0};
      5'd8:  s = '{dc: -3'sd2, dr: -3'sd3, far: 1'b1};
      5'd9:  s = '{dc: -3'sd2, dr: -3'sd2, far: 1'b1};
      5'd10: s = '{dc: -3'sd2, dr: -3'sd1, far: 1'b1};
      5'd11: s = '{dc: -3'sd2, dr:  3'sd0, far: 1'b1};
      5'd12: s = '{dc: -3'sd2, dr:  3'sd1, far: 1'b1};
      5'd13: s = '{dc: -3'sd2, dr:  3'sd2, far: 1'b1};
      5'd14: s = '{dc: -3'sd2, dr:  3'sd3, far: 1'b1};
      5'd15: s = '{dc:  3'sd2, dr: -3'sd3, far: 1'b1};
      5'd16: s = '{dc:  3'sd2, dr: -3'sd2, far: 1'b1};
      5'd17: s = '{dc:  3'sd2, dr: -3'sd1, far: 1'b1};
      5'd18: s = '{dc:  3'sd2, dr:  3'sd0, far: 1'b1};
      5'd19: s = '{dc:  3'sd2, dr:  3'sd1, far: 1'b1};
      5'd20: s = '{dc:  3'sd2, dr:  3'sd2, far: 1'b1};
      5'd21: s = '{dc:  3'sd2, dr:  3'sd3, far: 1'b1};
      5'd22: s = '{dc: -3'sd1, dr: -3'sd2, far: 1'b1};
      5'd23: s = '{dc:  3'sd0, dr: -3'sd2, far: 1'b1};
      5'd24: s = '{dc:  3'sd1, dr: -3'sd2, far: 1'b1};
      5'd25: s = '{dc: -3'sd1, dr:  3'sd2, far: 1'b1};
      5'd26: s = '{dc:  3'sd0, dr:  3'sd2, far: 1'b1};
      5'd27: s = '{dc:  3'sd1, dr:  3'sd2, far: 1'b1};
      default: s = '{dc: 3'sd0, dr: 3'sd0, far: 1'b0};
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/drac_if.sv
`default_nettype none

interface drac_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [drac_pkg::CoordW-1:0] col;
  logic [drac_pkg::CoordW-1:0] row;
  logic                        cell_value;

  modport source (output valid, cmd, col, row, cell_value, input ready);
  modport sink   (input valid, cmd, col, row, cell_value, output ready);
endinterface

interface drac_out_if;
  logic                       valid;
  logic                       ready;
  logic                       next_state;
  logic [drac_pkg::NearW-1:0] near_count;
  logic [drac_pkg::FarW-1:0]  far_count;

  modport source (output valid, next_state, near_count, far_count, input ready);
  modport sink   (input valid, next_state, near_count, far_count, output ready);
endinterface

interface drac_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [drac_pkg::CfgIdxW-1:0] index;
  logic [drac_pkg::ThrW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/drac_ram.sv
`default_nettype none

module drac_ram #(
  parameter int Width = 1,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/drac_ctrl.sv
`default_nettype none

module drac_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire drac_pkg::dp_status_t status_i,
  output drac_pkg::dp_cmd_t         cmd_o
);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StReduce = 6'b000010,
    StWrite  = 6'b000100,
    StScan   = 6'b001000,
    StDrain  = 6'b010000,
    StFinish = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StReduce;
        end
      end
      StReduce: begin
        // coordinates folded into the grid one subtraction at a time
        if (!status_i.reduced) begin
          cmd_o.reduce = 1'b1;
        end else if (status_i.is_eval) begin
          cmd_o.clear_acc = 1'b1;
          state_d         = StScan;
        end else begin
          cmd_o.issue_center = 1'b1;
          state_d            = StWrite;
        end
      end
      StWrite: begin
        cmd_o.mem_write = 1'b1;
        state_d         = StIdle;
      end
      StScan: begin
        cmd_o.issue_step = 1'b1;
        if (status_i.last_step) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!status_i.pipe_busy) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/drac_datapath.sv
`default_nettype none

module drac_datapath #(
  parameter int GRID_WIDTH  = drac_pkg::GridWidth,
  parameter int GRID_HEIGHT = drac_pkg::GridHeight
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_cmd_i,
  input  wire logic [drac_pkg::CoordW-1:0] in_col_i,
  input  wire logic [drac_pkg::CoordW-1:0] in_row_i,
  input  wire logic                        in_cell_value_i,
  input  wire drac_pkg::dp_cmd_t           cmd_i,
  output drac_pkg::dp_status_t             status_o,
  drac_cfg_if.sink                         cfg_i,
  drac_out_if.source                       out_o
);

  localparam int CoordW  = drac_pkg::CoordW;
  localparam int NearW   = drac_pkg::NearW;
  localparam int FarW    = drac_pkg::FarW;
  localparam int ThrW    = drac_pkg::ThrW;
  localparam int StepW   = drac_pkg::StepW;
  localparam int ColW    = $clog2(GRID_WIDTH);
  localparam int RowW    = $clog2(GRID_HEIGHT);
  localparam int ColSumW = ColW + 2;
  localparam int RowSumW = RowW + 2;
  localparam int Depth   = GRID_WIDTH * GRID_HEIGHT;
  localparam int AddrW   = $clog2(Depth);
  localparam logic [StepW-1:0] LastStep = StepW'(drac_pkg::NumSteps - 1);

  // captured request
  logic              is_eval_q;
  logic              value_q;
  logic [CoordW-1:0] col_q;
  logic [CoordW-1:0] row_q;

  // scan pipeline
  logic [StepW-1:0]  step_q;
  logic [ColW-1:0]   x1_q;
  logic [RowW-1:0]   y1_q;
  logic              v1_q, far1_q;
  logic              v2_q, far2_q;
  logic [NearW-1:0]  near_cnt_q;
  logic [FarW-1:0]   far_cnt_q;

  logic [ThrW-1:0]   near_low_q, near_high_q, far_low_q, far_high_q;

  logic              out_valid_q;
  logic              out_live_q;
  logic [NearW-1:0]  out_near_q;
  logic [FarW-1:0]   out_far_q;

  drac_pkg::step_t   step;
  logic signed [2:0] dc, dr;
  logic [ColSumW-1:0] x_sum;
  logic [RowSumW-1:0] y_sum;
  logic [ColSumW-1:0] x_wrap;
  logic [RowSumW-1:0] y_wrap;
  logic [AddrW-1:0]   mem_addr;
  logic               mem_rdata;
  logic               col_big, row_big;
  logic               live;

  assign col_big = 32'(col_q) >= 32'(GRID_WIDTH);
  assign row_big = 32'(row_q) >= 32'(GRID_HEIGHT);

  // offset coordinates; base + size + delta lies in [size-3, 2*size+2]
  always_comb begin
    step = drac_pkg::step_offset(step_q);
    dc   = cmd_i.issue_center ? 3'sd0 : step.dc;
    dr   = cmd_i.issue_center ? 3'sd0 : step.dr;
    x_sum = ColSumW'(col_q) + ColSumW'(GRID_WIDTH) + ColSumW'(dc);
    y_sum = RowSumW'(row_q) + RowSumW'(GRID_HEIGHT) + RowSumW'(dr);
    x_wrap = (x_sum >= ColSumW'(2 * GRID_WIDTH)) ? x_sum - ColSumW'(2 * GRID_WIDTH) :
             (x_sum >= ColSumW'(GRID_WIDTH))     ? x_sum - ColSumW'(GRID_WIDTH) : x_sum;
    y_wrap = (y_sum >= RowSumW'(2 * GRID_HEIGHT)) ? y_sum - RowSumW'(2 * GRID_HEIGHT) :
             (y_sum >= RowSumW'(GRID_HEIGHT))     ? y_sum - RowSumW'(GRID_HEIGHT) : y_sum;
  end

  assign mem_addr = AddrW'(y1_q) * AddrW'(GRID_WIDTH) + AddrW'(x1_q);

  drac_ram #(
    .Width (1),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_write),
    .addr_i  (mem_addr),
    .wdata_i (value_q),
    .rdata_o (mem_rdata)
  );

  assign live = ({1'b0, near_cnt_q} > near_low_q) && ({1'b0, near_cnt_q} < near_high_q) &&
                (far_cnt_q > far_low_q) && (far_cnt_q < far_high_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      near_low_q  <= drac_pkg::NearLowRst;
      near_high_q <= drac_pkg::NearHighRst;
      far_low_q   <= drac_pkg::FarLowRst;
      far_high_q  <= drac_pkg::FarHighRst;
    end else begin
      if (cmd_i.clear_acc) begin
        step_q <= '0;
      end else if (cmd_i.issue_step) begin
        step_q <= step_q + StepW'(1);
      end
      v1_q <= cmd_i.issue_step;
      v2_q <= v1_q;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (drac_pkg::cfg_idx_e'(cfg_i.index))
          drac_pkg::CfgNearLow:  near_low_q  <= cfg_i.data;
          drac_pkg::CfgNearHigh: near_high_q <= cfg_i.data;
          drac_pkg::CfgFarLow:   far_low_q   <= cfg_i.data;
          drac_pkg::CfgFarHigh:  far_high_q  <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      is_eval_q <= in_cmd_i;
      value_q   <= in_cell_value_i;
      col_q     <= in_col_i;
      row_q     <= in_row_i;
    end else if (cmd_i.reduce) begin
      if (col_big) begin
        col_q <= col_q - CoordW'(GRID_WIDTH);
      end
      if (row_big) begin
        row_q <= row_q - CoordW'(GRID_HEIGHT);
      end
    end
    if (cmd_i.issue_step || cmd_i.issue_center) begin
      x1_q   <= x_wrap[ColW-1:0];
      y1_q   <= y_wrap[RowW-1:0];
      far1_q <= step.far;
    end
    far2_q <= far1_q;
    if (cmd_i.clear_acc) begin
      near_cnt_q <= '0;
      far_cnt_q  <= '0;
    end else if (v2_q) begin
      if (far2_q) begin
        far_cnt_q <= far_cnt_q + FarW'(mem_rdata);
      end else begin
        near_cnt_q <= near_cnt_q + NearW'(mem_rdata);
      end
    end
    if (cmd_i.load_out) begin
      out_live_q <= live;
      out_near_q <= near_cnt_q;
      out_far_q  <= far_cnt_q;
    end
  end

  assign status_o.reduced   = !col_big && !row_big;
  assign status_o.is_eval   = is_eval_q;
  assign status_o.last_step = (step_q == LastStep);
  assign status_o.pipe_busy = v1_q || v2_q;
  assign status_o.out_free  = !out_valid_q || out_o.ready;

  assign cfg_i.ready      = 1'b1;
  assign out_o.valid      = out_valid_q;
  assign out_o.next_state = out_live_q;
  assign out_o.near_count = out_near_q;
  assign out_o.far_count  = out_far_q;

endmodule

`default_nettype wire

>>> rtl/dual_ring_automaton_cell_rule_unit.sv
// Dual-ring cellular automaton cell rule.
// Requests arrive on in_i (valid/ready). A write request (cmd 0) stores
// cell_value at (col,row) of a toroidal one-bit grid; an evaluate request
// (cmd 1) counts the 8 Moore neighbors and the 20-cell outer ring and
// returns next_state, near_count and far_count on out_o. Writes give no
// result. Load every cell before the first evaluate; grid contents are
// undefined after reset.
// cfg_i writes the four 5-bit thresholds (near_low, near_high, far_low,
// far_high, index 0..3); it is always ready. Write it only while idle.
// Sequence: coordinates are first folded into the grid, one subtraction of the
// grid size at a time (none when the grid is 64 or wider). A write then
// stores the cell in the write state. An evaluate reads its 28 cells one per
// cycle through the single grid RAM port, then drains the address, read and
// accumulate registers and loads the result into out_o. Each request finishes
// before the next one is taken.
// The result register holds while out_o.ready is low; writes keep flowing,
// and the next evaluate waits in its final cycle until the slot frees.
// Reset (rst_ni, async low) restores default thresholds and empties out_o.
`default_nettype none

module dual_ring_automaton_cell_rule_unit #(
  parameter int GRID_WIDTH  = drac_pkg::GridWidth,
  parameter int GRID_HEIGHT = drac_pkg::GridHeight
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  drac_in_if.sink    in_i,
  drac_cfg_if.sink   cfg_i,
  drac_out_if.source out_o
);

  drac_pkg::dp_cmd_t    dp_cmd;
  drac_pkg::dp_status_t dp_status;
  logic                 in_ready;

  drac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  drac_datapath #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_cmd_i        (in_i.cmd),
    .in_col_i        (in_i.col),
    .in_row_i        (in_i.row),
    .in_cell_value_i (in_i.cell_value),
    .cmd_i           (dp_cmd),
    .status_o        (dp_status),
    .cfg_i           (cfg_i),
    .out_o           (out_o)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire

>>> sim/drac_tb_pkg.sv
`timescale 1ns / 1ps

package drac_tb_pkg;

  typedef enum logic {
    CmdWrite = 1'b0,
    CmdEval  = 1'b1
  } drac_cmd_e;

endpackage

>>> sim/drac_rule_checker.sv
`timescale 1ns / 1ps

module drac_rule_checker (
  input  logic clk_i,
  input  logic rst_ni,
  drac_in_if   in_w,
  drac_cfg_if  cfg_w,
  drac_out_if  out_w,
  output int   errors_o,
  output int   pending_o
);
  import drac_pkg::*;
  import drac_tb_pkg::*;

  typedef struct packed {
    logic             next_state;
    logic [NearW-1:0] near_count;
    logic [FarW-1:0]  far_count;
  } cell_verdict_t;

  bit              grid [GridHeight][GridWidth];
  logic [ThrW-1:0] near_lo, near_hi, far_lo, far_hi;
  cell_verdict_t   verdict_q [$];
  int              errors;

  function automatic bit cell_at(int col, int row);
    return grid[(row + GridHeight) % GridHeight][(col + GridWidth) % GridWidth];
  endfunction

  function automatic cell_verdict_t rule_at(int col, int row);
    cell_verdict_t v;
    int nearc = 0;
    int farc = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr != 0 || dc != 0) nearc += cell_at(col + dc, row + dr);
      end
    end
    // outer ring: two full columns at +-2, then the short rows at +-2
    for (int d = -3; d <= 3; d++) begin
      farc += cell_at(col - 2, row + d);
      farc += cell_at(col + 2, row + d);
    end
    for (int d = -1; d <= 1; d++) begin
      farc += cell_at(col + d, row - 2);
      farc += cell_at(col + d, row + 2);
    end
    v.near_count = nearc[NearW-1:0];
    v.far_count  = farc[FarW-1:0];
    v.next_state = nearc > int'(near_lo) && nearc < int'(near_hi) &&
                   farc > int'(far_lo) && farc < int'(far_hi);
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cell_verdict_t want;
    if (!rst_ni) begin
      near_lo = NearLowRst;
      near_hi = NearHighRst;
      far_lo  = FarLowRst;
      far_hi  = FarHighRst;
      verdict_q.delete();
      errors = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_w.valid && cfg_w.ready) begin
        case (cfg_idx_e'(cfg_w.index))
          CfgNearLow:  near_lo = cfg_w.data;
          CfgNearHigh: near_hi = cfg_w.data;
          CfgFarLow:   far_lo  = cfg_w.data;
          CfgFarHigh:  far_hi  = cfg_w.data;
          default: ;
        endcase
      end
      if (out_w.valid && out_w.ready) begin
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result with no request pending", $realtime);
        end else begin
          want = verdict_q.pop_front();
          if (out_w.next_state !== want.next_state || out_w.near_count !== want.near_count ||
              out_w.far_count !== want.far_count) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch exp next=%0d near=%0d far=%0d got next=%0d near=%0d far=%0d",
                       $realtime, want.next_state, want.near_count, want.far_count,
                       out_w.next_state, out_w.near_count, out_w.far_count);
            end
          end
        end
      end
      if (in_w.valid && in_w.ready) begin
        if (drac_cmd_e'(in_w.cmd) == CmdEval) verdict_q.push_back(rule_at(in_w.col, in_w.row));
        else grid[in_w.row][in_w.col] = in_w.cell_value;
      end
      errors_o <= errors;
      pending_o <= verdict_q.size();
    end
  end

endmodule

>>> sim/dual_ring_automaton_cell_rule_unit_test.sv
`timescale 1ns / 1ps

module dual_ring_automaton_cell_rule_unit_test;
  import drac_pkg::*;
  import drac_tb_pkg::*;

  localparam int SettleCycles = 40;
  localparam int HoldCycles   = 400;
  localparam int CycleLimit   = 1000000;

  logic clk = 1'b0;
  logic rst_n;
  int   errors;
  int   pending;
  int   cycles = 0;
  bit   idle_on = 1'b1;
  bit   hold_go = 1'b0;
  int   hot_col, hot_row;

  drac_in_if  in_w ();
  drac_cfg_if cfg_w ();
  drac_out_if out_w ();

  dual_ring_automaton_cell_rule_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_w),
    .cfg_i (cfg_w),
    .out_o (out_w)
  );

  drac_rule_checker u_rule_check (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .in_w     (in_w),
    .cfg_w    (cfg_w),
    .out_w    (out_w),
    .errors_o (errors),
    .pending_o(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // called just after a rising clock; returns when the request is taken
  task automatic send_req(input drac_cmd_e cmd, input int col, input int row, input bit val);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_w.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_w.valid      <= 1'b1;
    in_w.cmd        <= cmd;
    in_w.col        <= col[CoordW-1:0];
    in_w.row        <= row[CoordW-1:0];
    in_w.cell_value <= val;
    @(posedge clk);
    while (in_w.ready !== 1'b1) @(posedge clk);
  endtask

  // wait for every result, then let trailing writes retire
  task automatic settle();
    in_w.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_thresholds(input logic [ThrW-1:0] nl, input logic [ThrW-1:0] nh,
                                  input logic [ThrW-1:0] fl, input logic [ThrW-1:0] fh);
    cfg_idx_e        regs [4] = '{CfgNearLow, CfgNearHigh, CfgFarLow, CfgFarHigh};
    logic [ThrW-1:0] vals [4];
    vals = '{nl, nh, fl, fh};
    for (int i = 0; i < 4; i++) begin
      cfg_w.valid <= 1'b1;
      cfg_w.index <= regs[i];
      cfg_w.data  <= vals[i];
      @(posedge clk);
      while (cfg_w.ready !== 1'b1) @(posedge clk);
    end
    cfg_w.valid <= 1'b0;
  endtask

  task automatic load_grid(input int density);
    for (int r = 0; r < GridHeight; r++) begin
      for (int c = 0; c < GridWidth; c++) begin
        send_req(CmdWrite, c, r, $urandom_range(1, 100) <= density);
      end
    end
  endtask

  // 5x7 block around a cell covers its whole neighborhood
  task automatic fill_patch(input int col, input int row, input bit val);
    for (int dr = -3; dr <= 3; dr++) begin
      for (int dc = -2; dc <= 2; dc++) begin
        send_req(CmdWrite, (col + dc + GridWidth) % GridWidth,
                 (row + dr + GridHeight) % GridHeight, val);
      end
    end
  endtask

  // half the requests land in a small hot spot so writes change what evaluates see
  task automatic random_items(input int count, input int eval_pct);
    int col, row;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1)) begin
        col = (hot_col + $urandom_range(0, 7)) % GridWidth;
        row = (hot_row + $urandom_range(0, 7)) % GridHeight;
      end else begin
        col = $urandom_range(0, GridWidth - 1);
        row = $urandom_range(0, GridHeight - 1);
      end
      if ($urandom_range(1, 100) <= eval_pct) begin
        send_req(CmdEval, col, row, 1'($urandom_range(0, 1)));
      end else begin
        send_req(CmdWrite, col, row, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // result side
  initial begin
    int gap;
    out_w.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        out_w.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        out_w.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_w.ready <= 1'b1;
      @(posedge clk);
      while (out_w.valid !== 1'b1) @(posedge clk);
    end
  end

  initial begin
    logic [ThrW-1:0] nl, nh, fl, fh;
    rst_n           <= 1'b0;
    in_w.valid      <= 1'b0;
    in_w.cmd        <= CmdWrite;
    in_w.col        <= '0;
    in_w.row        <= '0;
    in_w.cell_value <= 1'b0;
    cfg_w.valid     <= 1'b0;
    cfg_w.index     <= CfgNearLow;
    cfg_w.data      <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_grid($urandom_range(25, 75));

    // cleared neighborhoods: both counts zero, wrapping at the corners
    fill_patch(0, 0, 1'b0);
    send_req(CmdEval, 0, 0, 1'b1);
    fill_patch(GridWidth - 1, GridHeight - 1, 1'b0);
    send_req(CmdEval, GridWidth - 1, GridHeight - 1, 1'b0);

    // filled neighborhoods: counts at their maximum
    fill_patch(0, GridHeight - 1, 1'b1);
    send_req(CmdEval, 0, GridHeight - 1, 1'b0);
    fill_patch(GridWidth - 1, 0, 1'b1);
    send_req(CmdEval, GridWidth - 1, 0, 1'b1);
    fill_patch(31, 32, 1'b1);
    send_req(CmdEval, 31, 32, 1'b0);
    fill_patch(0, 0, 1'b1);
    fill_patch(GridWidth - 1, GridHeight - 1, 1'b1);
    settle();
    write_thresholds(7, 9, 19, 21);
    send_req(CmdEval, 0, 0, 1'b0);
    send_req(CmdEval, GridWidth - 1, GridHeight - 1, 1'b0);
    settle();
    write_thresholds(0, 31, 0, 31);
    send_req(CmdEval, 5, 60, 1'b0);
    settle();
    write_thresholds(31, 0, 31, 0);
    send_req(CmdEval, 40, 2, 1'b1);
    // low just one under high: no count fits between
    settle();
    write_thresholds(7, 8, 19, 20);
    send_req(CmdEval, 0, 0, 1'b0);
    settle();
    write_thresholds(5, 7, 18, 20);
    send_req(CmdWrite, GridWidth - 1, 0, 1'b0);
    send_req(CmdWrite, 1, 1, 1'b0);
    send_req(CmdWrite, 2, 2, 1'b0);
    send_req(CmdEval, 0, 0, 1'b1);
    send_req(CmdEval, 1, 0, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      idle_on = (ph != 2);
      hot_col = $urandom_range(0, GridWidth - 1);
      hot_row = $urandom_range(0, GridHeight - 1);
      nl = ThrW'($urandom_range(0, 5));
      nh = nl + ThrW'($urandom_range(2, 5));
      fl = ThrW'($urandom_range(3, 11));
      fh = fl + ThrW'($urandom_range(2, 8));
      case (ph)
        1: write_thresholds(0, 31, 0, 31);
        3: write_thresholds(31, 0, 31, 0);
        4: write_thresholds(ThrW'($urandom_range(0, 31)), ThrW'($urandom_range(0, 31)),
                            ThrW'($urandom_range(0, 31)), ThrW'($urandom_range(0, 31)));
        5: write_thresholds(NearLowRst, NearHighRst, FarLowRst, FarHighRst);
        default: write_thresholds(nl, nh, fl, fh);
      endcase
      if (ph == 1) hold_go = 1'b1;
      if (ph == 3) begin
        random_items(150, 50);
        settle();
        random_items(150, 50);
      end else begin
        random_items(300, 50);
      end
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
